### rtl/core/lpht_pkg.sv
// Shared types, sizes and codes for the linear probe hash table unit.
// Used by every module in rtl/core; depends on nothing.
package lpht_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BITS    = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // configuration register width and derived compare width
  localparam int CFG_W = 5;
  localparam int CMP_W = (CFG_W > IDX_W + 1) ? CFG_W : IDX_W + 1;

  // result field widths
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;

  // remainder unit: four dividend bits per cycle
  localparam int MOD_BITS  = 4;
  localparam int KEY_PAD   = ((KEY_BITS + MOD_BITS - 1) / MOD_BITS) * MOD_BITS;
  localparam int MOD_CYC   = KEY_PAD / MOD_BITS;
  localparam int MOD_CNT_W = $clog2(MOD_CYC + 1);

  // register port
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_HASH_DIV   = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_TABLE_SIZE = 1'd1;
  localparam logic [CFG_W-1:0]     HASH_DIV_RST   = 5'd13;
  localparam logic [CFG_W-1:0]     TABLE_SIZE_RST = 5'd16;

  // request codes
  localparam logic [1:0] REQ_SEARCH = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [KEY_BITS-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [COUNT_W-1:0]  compare_count;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic start_hash;
    logic start_wrap;
    logic set_home;
    logic probe;
    logic push;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hash_done;
    logic wrap_needed;
    logic probe_done;
  } dp_stat_t;

endpackage

### rtl/core/linear_probe_hash_table_unit.sv
// Linear probe hash table unit (needs lpht_pkg, lpht_ctrl, lpht_dp, lpht_mod).
// One request at a time: search, insert, clear, each giving one result word.
// A search or insert is accepted, then its key remainder is taken in the shared
// remainder unit (four key bits per cycle), and taken again by the size in use
// when the remainder falls outside that size; then slots are probed in turn
// (up to the size in use) and the result is handed off. Clear and the unused
// request type skip hashing and probing and go straight to handoff.
// A result waits in an output register, so the next request is taken while
// it is still stalled. Registers: hash divisor at 0x0, table size at 0x4.
module linear_probe_hash_table_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  lpht_pkg::in_word_t           in_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output lpht_pkg::out_word_t          out_word,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lpht_pkg::ADDR_W-1:0]  paddr,
  input  logic [lpht_pkg::DATA_W-1:0]  pwdata,
  output logic [lpht_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import lpht_pkg::*;

  logic [CFG_W-1:0]     hash_div_r;
  logic [CFG_W-1:0]     table_size_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  dp_cmd_t              cmd;
  dp_stat_t             stat;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_div_r   <= HASH_DIV_RST;
      table_size_r <= TABLE_SIZE_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_HASH_DIV:   hash_div_r   <= pwdata[CFG_W-1:0];
        REG_TABLE_SIZE: table_size_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HASH_DIV:   prdata = DATA_W'(hash_div_r);
      REG_TABLE_SIZE: prdata = DATA_W'(table_size_r);
      default:        prdata = '0;
    endcase
  end

  // controller
  lpht_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_word.req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .stat        (stat)
  );

  // datapath
  lpht_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_word  (in_word),
    .cfg_div  (hash_div_r),
    .cfg_size (table_size_r),
    .out_word (out_word)
  );

endmodule

### rtl/core/lpht_mod.sv
// Iterative remainder unit, four dividend bits per cycle (restoring).
// Depends on lpht_pkg.
module lpht_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lpht_pkg::KEY_PAD-1:0] dividend,
  input  logic [lpht_pkg::CFG_W-1:0]   divisor,
  output logic                        done,
  output logic [lpht_pkg::CFG_W-1:0]   rem
);
  import lpht_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [MOD_CNT_W-1:0] cnt_r;
  logic [KEY_PAD-1:0]   shift_r;
  logic [KEY_PAD-1:0]   shift_nxt;
  logic [CFG_W-1:0]     div_r;
  logic [CFG_W-1:0]     rem_r;
  logic [CFG_W-1:0]     rem_nxt;

  // four shift-and-subtract steps on the remainder
  always_comb begin
    logic [CFG_W:0] part;
    part = {1'b0, rem_r};
    for (int i = 0; i < MOD_BITS; i++) begin
      part = {part[CFG_W-1:0], shift_r[KEY_PAD-1-i]};
      if (part >= {1'b0, div_r}) begin
        part = part - {1'b0, div_r};
      end
    end
    rem_nxt   = part[CFG_W-1:0];
    shift_nxt = shift_r << MOD_BITS;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MOD_CNT_W'(MOD_CYC - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      shift_r <= dividend;
      div_r   <= divisor;
      rem_r   <= '0;
    end else if (busy_r) begin
      shift_r <= shift_nxt;
      rem_r   <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### rtl/core/lpht_dp.sv
// Datapath: slot store, home slot reduction, probe pointer and result registers.
// Depends on lpht_pkg and lpht_mod.
module lpht_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lpht_pkg::dp_cmd_t         cmd,
  output lpht_pkg::dp_stat_t        stat,
  input  lpht_pkg::in_word_t        in_word,
  input  logic [lpht_pkg::CFG_W-1:0] cfg_div,
  input  logic [lpht_pkg::CFG_W-1:0] cfg_size,
  output lpht_pkg::out_word_t       out_word
);
  import lpht_pkg::*;

  // request and probe state
  logic [1:0]          req_r;
  logic [KEY_BITS-1:0] key_r;
  logic [IDX_W-1:0]    home_r;
  logic [IDX_W-1:0]    ptr_r;
  logic [CFG_W-1:0]    cnt_r;
  out_word_t           res_r;
  out_word_t           out_word_r;

  // slot store
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [KEY_BITS-1:0]    key_mem [TABLE_DEPTH];
  logic [KEY_BITS-1:0]    slot_key_r;

  logic [CFG_W-1:0]   div_eff;
  logic [CFG_W-1:0]   size_eff;
  logic               mod_start;
  logic [KEY_PAD-1:0] mod_dividend;
  logic [CFG_W-1:0]   mod_divisor;
  logic               mod_done;
  logic [CFG_W-1:0]   mod_rem;
  logic [IDX_W-1:0]   home_val;
  logic [IDX_W-1:0]   ptr_next;
  logic [CFG_W-1:0]   cnt_inc;
  logic               slot_v;
  logic               slot_hit;
  logic               probe_fin;
  logic               ins_write;
  out_word_t          probe_res;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] p);
    logic [CMP_W-1:0] e;
    e = CMP_W'(p);
    return e[SLOT_W-1:0];
  endfunction

  // effective divisor and table size
  always_comb begin
    logic [CMP_W-1:0] s_ext;
    div_eff  = (cfg_div == '0) ? CFG_W'(1) : cfg_div;
    s_ext    = CMP_W'(cfg_size);
    if (cfg_size == '0) begin
      size_eff = CFG_W'(1);
    end else if (s_ext > CMP_W'(TABLE_DEPTH)) begin
      size_eff = CFG_W'(TABLE_DEPTH);
    end else begin
      size_eff = cfg_size;
    end
  end

  // remainder unit: key by divisor, then home by size when out of range
  assign mod_start    = cmd.start_hash | cmd.start_wrap;
  assign mod_dividend = cmd.start_wrap ? KEY_PAD'(mod_rem) : KEY_PAD'(in_word.key);
  assign mod_divisor  = cmd.start_wrap ? size_eff : div_eff;

  lpht_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    logic [CMP_W-1:0] r_ext;
    r_ext    = CMP_W'(mod_rem);
    home_val = r_ext[IDX_W-1:0];
  end

  // next probe slot, wrapping at the size in use
  always_comb begin
    logic [CMP_W-1:0] p_inc;
    p_inc = CMP_W'(ptr_r) + CMP_W'(1);
    if (p_inc == CMP_W'(size_eff)) begin
      ptr_next = '0;
    end else begin
      ptr_next = p_inc[IDX_W-1:0];
    end
  end

  // one probe step
  assign slot_v   = valid_r[ptr_r];
  assign slot_hit = (slot_key_r == key_r);
  assign cnt_inc  = cnt_r + 1'b1;

  always_comb begin
    probe_res = '0;
    ins_write = 1'b0;
    probe_fin = 1'b0;
    if (req_r == REQ_INSERT) begin
      if (!slot_v) begin
        ins_write = 1'b1;
        probe_fin = 1'b1;
        probe_res = '{status: ST_INSERTED, slot_index: slot_of(ptr_r),
                      compare_count: COUNT_W'(cnt_r)};
      end else if (cnt_inc == size_eff) begin
        probe_fin = 1'b1;
        probe_res = '{status: ST_FULL, slot_index: slot_of(home_r),
                      compare_count: COUNT_W'(size_eff)};
      end
    end else begin
      if (!slot_v || slot_hit || (ptr_next == home_r)) begin
        probe_fin = 1'b1;
        if (slot_v && slot_hit) begin
          probe_res = '{status: ST_FOUND, slot_index: slot_of(ptr_r),
                        compare_count: COUNT_W'(cnt_inc)};
        end else if (!slot_v) begin
          probe_res = '{status: ST_NOT_FOUND, slot_index: slot_of(ptr_r),
                        compare_count: COUNT_W'(cnt_inc)};
        end else begin
          probe_res = '{status: ST_NOT_FOUND, slot_index: slot_of(ptr_r),
                        compare_count: COUNT_W'(cnt_r)};
        end
      end
    end
  end

  // request, probe and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_word.req_type;
      key_r <= in_word.key;
      if (in_word.req_type == REQ_CLEAR) begin
        res_r <= '{status: ST_CLEARED, slot_index: '0, compare_count: '0};
      end else begin
        res_r <= '{status: ST_NOT_FOUND, slot_index: '0, compare_count: '0};
      end
    end
    if (cmd.set_home) begin
      home_r <= home_val;
      ptr_r  <= home_val;
      cnt_r  <= '0;
    end
    if (cmd.probe) begin
      if (probe_fin) begin
        res_r <= probe_res;
      end else begin
        ptr_r <= ptr_next;
        cnt_r <= cnt_inc;
      end
    end
    if (cmd.push) begin
      out_word_r <= res_r;
    end
  end

  // slot keys: write on insert, read one step ahead of the probe pointer
  always_ff @(posedge clk) begin
    if (cmd.probe && ins_write) begin
      key_mem[ptr_r] <= key_r;
    end
    if (cmd.set_home) begin
      slot_key_r <= key_mem[home_val];
    end else if (cmd.probe && !probe_fin) begin
      slot_key_r <= key_mem[ptr_next];
    end
  end

  // slot valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.load && (in_word.req_type == REQ_CLEAR)) begin
      valid_r <= '0;
    end else if (cmd.probe && ins_write) begin
      valid_r[ptr_r] <= 1'b1;
    end
  end

  assign stat.hash_done   = mod_done;
  assign stat.wrap_needed = (mod_rem >= size_eff);
  assign stat.probe_done  = probe_fin;
  assign out_word         = out_word_r;

endmodule

### rtl/core/lpht_ctrl.sv
// Controller state machine: sequences hashing, probing and result handoff.
// Depends on lpht_pkg.
module lpht_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_req_type,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output lpht_pkg::dp_cmd_t   cmd,
  input  lpht_pkg::dp_stat_t  stat
);
  import lpht_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_WRAP,
    S_PROBE,
    S_PUSH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   in_acc;
  logic   out_free;
  logic   needs_probe;

  assign in_acc      = in_valid && (state_r == S_IDLE);
  assign out_free    = !out_valid_r || !out_stall;
  assign needs_probe = (in_req_type == REQ_SEARCH) || (in_req_type == REQ_INSERT);

  // commands and next state
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.load = 1'b1;
          if (needs_probe) begin
            cmd.start_hash = 1'b1;
            state_nxt      = S_HASH;
          end else begin
            state_nxt = S_PUSH;
          end
        end
      end
      S_HASH: begin
        if (stat.hash_done) begin
          if (stat.wrap_needed) begin
            cmd.start_wrap = 1'b1;
            state_nxt      = S_WRAP;
          end else begin
            cmd.set_home = 1'b1;
            state_nxt    = S_PROBE;
          end
        end
      end
      S_WRAP: begin
        if (stat.hash_done) begin
          cmd.set_home = 1'b1;
          state_nxt    = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        if (stat.probe_done) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          cmd.push      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // an accepted request always leaves idle
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != S_IDLE)
    else $error("accepted request did not leave idle");

  // a new word only appears from the handoff state
  a_word_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_PUSH))
    else $error("output word raised outside handoff");

  // a finished probe goes straight to handoff
  a_probe_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PROBE && stat.probe_done |=> state_r == S_PUSH)
    else $error("finished probe did not reach handoff");

  // handoff never overwrites a word still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !out_valid_r || !out_stall)
    else $error("result pushed over a stalled word");

endmodule

### test/linear_probe_hash_table_unit_tb.sv
// Self-checking testbench for the linear probe hash table unit.
// Needs lpht_pkg and the unit's RTL; a scoreboard class tracks the slot table
// and checks every result word in order.
`timescale 1ns / 1ps

module linear_probe_hash_table_unit_tb;
  import lpht_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 114;
  localparam int HOLD_CYCLES  = 400;

  // tracks table contents and registers, predicts each result word
  class probe_scoreboard;
    bit          slot_used [TABLE_DEPTH];
    logic [KEY_BITS-1:0] slot_key [TABLE_DEPTH];
    logic [CFG_W-1:0]    divisor;
    logic [CFG_W-1:0]    size_reg;
    out_word_t   pending_results [$];
    int unsigned errors;
    int unsigned checked;

    function new();
      divisor  = HASH_DIV_RST;
      size_reg = TABLE_SIZE_RST;
      errors   = 0;
      checked  = 0;
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_key[i]  = '0;
      end
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == REG_HASH_DIV) divisor = value;
      else size_reg = value;
    endfunction

    function out_word_t mk(logic [STATUS_W-1:0] st, int unsigned slot, int unsigned cnt);
      out_word_t r;
      r.status        = st;
      r.slot_index    = slot[SLOT_W-1:0];
      r.compare_count = (cnt > 31) ? 5'd31 : cnt[COUNT_W-1:0];
      return r;
    endfunction

    // outcome of one request, updating the tracked table
    function out_word_t probe_outcome(in_word_t w);
      int unsigned sz, d, home, p, c, k;
      out_word_t r;
      bit done;
      sz = (size_reg == 0) ? 1 : ((size_reg > TABLE_DEPTH) ? TABLE_DEPTH : size_reg);
      d = (divisor == 0) ? 1 : divisor;
      home = w.key % d;
      if (home >= sz) home = home % sz;
      case (w.req_type)
        REQ_CLEAR: begin
          foreach (slot_used[i]) slot_used[i] = 1'b0;
          r = mk(ST_CLEARED, 0, 0);
        end
        REQ_UNUSED: r = mk(ST_NOT_FOUND, 0, 0);
        REQ_INSERT: begin
          // first free slot on the probe path, else table full
          r = mk(ST_FULL, home, sz);
          done = 1'b0;
          for (k = 0; k < sz; k++) begin
            p = (home + k) % sz;
            if (!done && !slot_used[p]) begin
              slot_used[p] = 1'b1;
              slot_key[p]  = w.key;
              r = mk(ST_INSERTED, p, k);
              done = 1'b1;
            end
          end
        end
        default: begin
          // walk until match, empty slot, or the wrap back to home
          p = home;
          c = 0;
          while (slot_used[p] && ((p + 1) % sz) != home && slot_key[p] != w.key) begin
            c++;
            p = (p + 1) % sz;
          end
          if (slot_used[p] && slot_key[p] == w.key) r = mk(ST_FOUND, p, c + 1);
          else begin
            if (!slot_used[p]) c++;
            r = mk(ST_NOT_FOUND, p, c);
          end
        end
      endcase
      return r;
    endfunction

    function void note_input(in_word_t w);
      pending_results.push_back(probe_outcome(w));
    endfunction

    function void note_error(string what, int unsigned exp_v, int unsigned act_v);
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
      errors++;
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result word with nothing outstanding: expected none, actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.status !== want.status) note_error("status", want.status, got.status);
      if (got.slot_index !== want.slot_index)
        note_error("slot_index", want.slot_index, got.slot_index);
      if (got.compare_count !== want.compare_count)
        note_error("compare_count", want.compare_count, got.compare_count);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_word_t            in_word   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_word_t           out_word;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ADDR_W-1:0]   paddr     = '0;
  logic [DATA_W-1:0]   pwdata    = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  probe_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_left     = 0;
  int sent_words    = 0;
  int reg_settings  = 0;
  logic [KEY_BITS-1:0] key_pool [$];

  linear_probe_hash_table_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // clock, 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // result side stall: random, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // check each accepted result word
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_word);
  end

  // run limit
  initial begin
    #5_000_000;
    $display("** linear_probe_hash_table_unit: FAILED **");
    $finish;
  end

  function in_word_t mkw(logic [1:0] req, logic [KEY_BITS-1:0] key);
    in_word_t w;
    w.req_type = req;
    w.key      = key;
    return w;
  endfunction

  // offer one word, optionally after a gap; returns just after a falling edge
  task send_word(input in_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    sb.note_input(w);
    sent_words++;
    if (w.req_type == REQ_INSERT) begin
      key_pool.push_back(w.key);
      if (key_pool.size() > 64) void'(key_pool.pop_front());
    end
    @(negedge clk);
  endtask

  // stop offering and let every outstanding result drain
  task wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // register write then read-back over the APB port
  task write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    logic [DATA_W-1:0] wdata;
    wdata = $urandom;
    wdata[CFG_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    reg_settings++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CFG_W-1:0] !== value) sb.note_error("register read", value, prdata[CFG_W-1:0]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task set_table(input logic [CFG_W-1:0] div, input logic [CFG_W-1:0] size);
    wait_idle();
    write_reg(REG_HASH_DIV, div);
    write_reg(REG_TABLE_SIZE, size);
  endtask

  // mostly inserts and searches of live or colliding keys, some clears and noise
  function in_word_t random_word();
    int unsigned r, kr;
    logic [KEY_BITS-1:0] key;
    logic [1:0] req;
    r  = $urandom_range(99);
    kr = $urandom_range(99);
    if (r < 4) req = REQ_CLEAR;
    else if (r < 7) req = REQ_UNUSED;
    else if (r < 50) req = REQ_INSERT;
    else req = REQ_SEARCH;
    if (kr < 45 && key_pool.size() != 0)
      key = key_pool[$urandom_range(key_pool.size() - 1)];
    else if (kr < 75)
      key = KEY_BITS'($urandom_range(31) + sb.divisor * $urandom_range(2000));
    else
      key = KEY_BITS'($urandom);
    return mkw(req, key);
  endfunction

  initial begin
    logic [CFG_W-1:0] div, size;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset registers, collisions on home slot 0, duplicates
    send_word(mkw(REQ_SEARCH, 16'd0));
    send_word(mkw(REQ_INSERT, 16'd0));
    send_word(mkw(REQ_INSERT, 16'd13));
    send_word(mkw(REQ_INSERT, 16'd26));
    send_word(mkw(REQ_INSERT, 16'hFFFF));
    send_word(mkw(REQ_INSERT, 16'd0));
    send_word(mkw(REQ_SEARCH, 16'd13));
    send_word(mkw(REQ_SEARCH, 16'd39));
    send_word(mkw(REQ_SEARCH, 16'd26));
    send_word(mkw(REQ_UNUSED, 16'hFFFF));
    send_word(mkw(REQ_CLEAR, 16'hFFFF));
    send_word(mkw(REQ_SEARCH, 16'd0));

    // directed: fill a small table, full insert and full wrap on search
    set_table(5'd1, 5'd4);
    send_word(mkw(REQ_INSERT, 16'd5));
    send_word(mkw(REQ_INSERT, 16'd6));
    send_word(mkw(REQ_INSERT, 16'd7));
    send_word(mkw(REQ_INSERT, 16'd8));
    send_word(mkw(REQ_INSERT, 16'd9));
    send_word(mkw(REQ_SEARCH, 16'd100));
    send_word(mkw(REQ_SEARCH, 16'd7));

    // directed: home slot beyond a one-slot table
    set_table(5'd16, 5'd1);
    send_word(mkw(REQ_INSERT, 16'hFFFF));
    send_word(mkw(REQ_SEARCH, 16'hFFFF));
    send_word(mkw(REQ_SEARCH, 16'd5));
    send_word(mkw(REQ_CLEAR, 16'd0));
    send_word(mkw(REQ_INSERT, 16'hFFFF));

    // random phases over register settings and idling patterns
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin div = 5'd13; size = 5'd16; end
        1: begin div = 5'd1;  size = 5'd1;  end
        2: begin div = 5'd16; size = 5'd16; end
        3: begin div = 5'd0;  size = 5'd0;  end
        4: begin div = 5'd31; size = 5'd31; end
        5: begin div = 5'd7;  size = 5'd10; end
        6: begin div = 5'd3;  size = 5'd5;  end
        default: begin
          div  = CFG_W'($urandom_range(31));
          size = CFG_W'($urandom_range(31));
        end
      endcase
      set_table(div, size);
      if (ph < 3) begin
        send_idle_pct = 26;
        recv_idle_pct = 80;
      end else if (ph < 6) begin
        send_idle_pct = 80;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long hold-off on the result side so the unit backs up its input
      if (ph == 6) hold_req = HOLD_CYCLES;
      for (int i = 0; i < PHASE_ITEMS; i++) send_word(random_word());
    end

    wait_idle();
    if (sb.pending() != 0) sb.note_error("outstanding results", 0, sb.pending());
    $display("covered %0d requests in %0d register writes, %0d result words checked",
             sent_words, reg_settings, sb.checked);
    $display("search, insert, clear, unused type, full table, wrap, divisor and size extremes");
    if (sb.errors == 0) begin
      $display("** linear_probe_hash_table_unit: PASSED **");
    end else begin
      $display("** linear_probe_hash_table_unit: FAILED **");
    end
    $finish;
  end

endmodule
